### hdl/assert_macros.svh
// assertion macros used by the rtl files
// no dependencies; take in with a bare include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/uci_pkg.sv
// shared widths and types for the unique/count/inverse block
// no dependencies
package uci_pkg;

    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 6;
    localparam int OCC_W   = 7;

    // status from the shared compare unit
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

### hdl/uci_if.sv
// valid/ready channel interfaces for input items and results
// depends on uci_pkg
interface uci_item_if;
    logic                               valid;
    logic                               ready;
    logic signed [uci_pkg::VALUE_W-1:0] value;
    logic                               last;

    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

interface uci_result_if;
    logic                               valid;
    logic                               ready;
    logic        [uci_pkg::SLOT_W-1:0]  slot;
    logic                               distinct_valid;
    logic signed [uci_pkg::VALUE_W-1:0] distinct_value;
    logic        [uci_pkg::OCC_W-1:0]   occurrences;
    logic        [uci_pkg::SLOT_W-1:0]  inverse_index;
    logic                               overflow;
    logic                               end_of_batch;

    modport source (output valid, slot, distinct_valid, distinct_value, occurrences,
                    inverse_index, overflow, end_of_batch, input ready);
    modport sink   (input valid, slot, distinct_valid, distinct_value, occurrences,
                    inverse_index, overflow, end_of_batch, output ready);
endinterface

### hdl/unique_count_inverse.sv
// Sorted unique values with occurrence counts and inverse indices over a batch of
// signed 32-bit values. Values arrive one beat at a time on item until a beat with
// last set; the block then sends one result beat per stored value. Result slot k
// carries the k-th distinct value in ascending signed order with its count (if it
// exists) and the distinct-list position of the k-th stored value. Beats beyond
// MAX_ITEMS are dropped and flagged through overflow on every result of the batch.
// All work goes through one compare unit that scans the value store, one entry per
// cycle, and the block takes no item while it works. Storing a value runs a duplicate
// check against the values already held. The closing beat then runs one full scan of
// the n stored values per value before the first result, and each result passes
// through S_ORD and S_OSEND and waits there for result.ready. No clearing pass is
// needed after reset.
// depends on uci_pkg, uci_if, uci_cmp and assert_macros.svh
`include "assert_macros.svh"

module unique_count_inverse #(
    parameter int MAX_ITEMS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    uci_item_if.sink     item,
    uci_result_if.source result
);

    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,   // ready for a beat
        S_LSCAN = 8'b0000_0010,   // duplicate check of a new value against held ones
        S_FETCH = 8'b0000_0100,   // read value i
        S_LOADV = 8'b0000_1000,   // latch value i
        S_SCAN  = 8'b0001_0000,   // rank and count value i over the store
        S_STORE = 8'b0010_0000,   // write rank and distinct entry
        S_ORD   = 8'b0100_0000,   // read result tables at slot
        S_OSEND = 8'b1000_0000    // result beat on offer
    } state_t;

    // sequencer and batch state
    state_t                       state_reg, state_next;
    logic [CW-1:0]                cnt_reg, cnt_next;      // values held
    logic                         drop_reg, drop_next;    // beats dropped
    logic                         last_reg, last_next;
    logic [MAX_ITEMS-1:0]         first_reg, first_next;  // first occurrence flags
    logic [CW-1:0]                nd_reg, nd_next;        // distinct values so far
    logic [CW-1:0]                i_reg, i_next;          // value / slot index

    // scan engine
    logic [CW-1:0]                j_reg, j_next;          // issue index
    logic                         pend_reg, pend_next;    // read data in flight
    logic [IW-1:0]                jd_reg, jd_next;        // index of data in flight
    logic signed [uci_pkg::VALUE_W-1:0] hold_reg, hold_next;
    logic                         eqs_reg, eqs_next;      // duplicate seen
    logic [IW-1:0]                rank_reg, rank_next;    // distinct values below
    logic [CW-1:0]                occ_reg, occ_next;      // equal values

    logic                         issue;
    logic                         scan_done;
    logic                         scanning;
    logic                         accept;
    logic                         val_rd_en;
    logic [IW-1:0]                val_rd_addr;
    logic                         last_slot;
    logic                         dv;
    uci_pkg::cmp_res_t            cmp;

    // memories
    logic signed [uci_pkg::VALUE_W-1:0] val_mem  [MAX_ITEMS];
    logic [IW-1:0]                      rank_mem [MAX_ITEMS];
    logic signed [uci_pkg::VALUE_W-1:0] dval_mem [MAX_ITEMS];
    logic [CW-1:0]                      docc_mem [MAX_ITEMS];
    logic signed [uci_pkg::VALUE_W-1:0] val_rd;
    logic [IW-1:0]                      rank_rd;
    logic signed [uci_pkg::VALUE_W-1:0] dval_rd;
    logic [CW-1:0]                      docc_rd;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;

    // one read of the value store per cycle: value i on fetch, entry j while scanning
    assign scanning    = (state_reg == S_LSCAN) || (state_reg == S_SCAN);
    assign issue       = scanning && (j_reg < cnt_reg);
    assign scan_done   = scanning && !issue && !pend_reg;
    assign val_rd_en   = (state_reg == S_FETCH) || issue;
    assign val_rd_addr = (state_reg == S_FETCH) ? i_reg[IW-1:0] : j_reg[IW-1:0];

    uci_cmp u_cmp (
        .a   (val_rd),
        .b   (hold_reg),
        .res (cmp)
    );

    // value store: written on an accepted beat, read by the scan engine
    always_ff @(posedge clk)
    begin
        if (accept && (cnt_reg < CW'(MAX_ITEMS)))
        begin
            val_mem[cnt_reg[IW-1:0]] <= item.value;
        end
        if (val_rd_en)
        begin
            val_rd <= val_mem[val_rd_addr];
        end
    end

    // result tables: inverse index per value, distinct value and count per rank
    always_ff @(posedge clk)
    begin
        if (state_reg == S_STORE)
        begin
            rank_mem[i_reg[IW-1:0]] <= rank_reg;
            if (first_reg[i_reg[IW-1:0]])
            begin
                dval_mem[rank_reg] <= hold_reg;
                docc_mem[rank_reg] <= occ_reg;
            end
        end
        if (state_reg == S_ORD)
        begin
            rank_rd <= rank_mem[i_reg[IW-1:0]];
            dval_rd <= dval_mem[i_reg[IW-1:0]];
            docc_rd <= docc_mem[i_reg[IW-1:0]];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        last_next  = last_reg;
        first_next = first_reg;
        nd_next    = nd_reg;
        i_next     = i_reg;
        hold_next  = hold_reg;
        eqs_next   = eqs_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;

        // scan engine advance
        j_next    = issue ? (j_reg + CW'(1)) : j_reg;
        pend_next = issue;
        jd_next   = j_reg[IW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = item.last;
                    if (cnt_reg < CW'(MAX_ITEMS))
                    begin
                        hold_next  = item.value;
                        eqs_next   = 1'b0;
                        j_next     = '0;
                        pend_next  = 1'b0;
                        state_next = S_LSCAN;
                    end
                    else
                    begin
                        // store full: drop the beat, a closing beat still ends the batch
                        drop_next = 1'b1;
                        if (item.last)
                        begin
                            i_next     = '0;
                            nd_next    = '0;
                            state_next = S_FETCH;
                        end
                    end
                end
            end
            S_LSCAN:
            begin
                if (pend_reg && cmp.eq)
                begin
                    eqs_next = 1'b1;
                end
                if (scan_done)
                begin
                    first_next[cnt_reg[IW-1:0]] = !eqs_reg;
                    cnt_next = cnt_reg + CW'(1);
                    if (last_reg)
                    begin
                        i_next     = '0;
                        nd_next    = '0;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_LOADV;
            end
            S_LOADV:
            begin
                hold_next  = val_rd;
                j_next     = '0;
                pend_next  = 1'b0;
                rank_next  = '0;
                occ_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (pend_reg && cmp.eq)
                begin
                    occ_next = occ_reg + CW'(1);
                end
                // only first occurrences count towards the rank
                if (pend_reg && cmp.lt && first_reg[jd_reg])
                begin
                    rank_next = rank_reg + IW'(1);
                end
                if (scan_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                nd_next = nd_reg + CW'(first_reg[i_reg[IW-1:0]]);
                if ((i_reg + CW'(1)) == cnt_reg)
                begin
                    i_next     = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_FETCH;
                end
            end
            S_ORD:
            begin
                state_next = S_OSEND;
            end
            S_OSEND:
            begin
                if (result.ready)
                begin
                    if (last_slot)
                    begin
                        // batch done: clear for the next one
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        i_next     = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            last_reg  <= 1'b0;
            first_reg <= '0;
            nd_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            last_reg  <= last_next;
            first_reg <= first_next;
            nd_reg    <= nd_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pend_reg  <= pend_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        jd_reg   <= jd_next;
        hold_reg <= hold_next;
        eqs_reg  <= eqs_next;
        rank_reg <= rank_next;
        occ_reg  <= occ_next;
    end

    // result beat, all fields from registers or registered table reads
    assign last_slot = ((i_reg + CW'(1)) == cnt_reg);
    assign dv        = (i_reg < nd_reg);

    assign result.valid          = (state_reg == S_OSEND);
    assign result.slot           = uci_pkg::SLOT_W'(i_reg);
    assign result.distinct_valid = dv;
    assign result.distinct_value = dv ? dval_rd : '0;
    assign result.occurrences    = dv ? uci_pkg::OCC_W'(docc_rd) : '0;
    assign result.inverse_index  = uci_pkg::SLOT_W'(rank_rd);
    assign result.overflow       = drop_reg;
    assign result.end_of_batch   = last_slot;

    // the store never holds more than its depth
    `ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CW'(MAX_ITEMS))
    // distinct values never outnumber held values, and results stay within the batch
    `ASSERT_IMP(a_out_slot, clk, rst_n, result.valid, (i_reg < cnt_reg) && (nd_reg <= cnt_reg))
    // a beat arriving on a full store is flagged
    `ASSERT_NEXT(a_drop_flag, clk, rst_n, accept && (cnt_reg == CW'(MAX_ITEMS)), drop_reg)
    // the last result beat clears the batch
    `ASSERT_NEXT(a_batch_clear, clk, rst_n, result.valid && result.ready && result.end_of_batch,
                 (cnt_reg == '0) && !drop_reg && item.ready)

endmodule

### hdl/uci_cmp.sv
// shared compare unit: equality and signed less-than of two values
// depends on uci_pkg
module uci_cmp (
    input  logic signed [uci_pkg::VALUE_W-1:0] a,
    input  logic signed [uci_pkg::VALUE_W-1:0] b,
    output uci_pkg::cmp_res_t                  res
);

    assign res.eq = (a == b);
    assign res.lt = (a < b);

endmodule
